// File: rtl/mcb_arena_allocator_macros.svh
// Assertion macros shared by the arena allocator RTL.
`ifndef MCB_ARENA_ALLOCATOR_MACROS_SVH
`define MCB_ARENA_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define MCB_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define MCB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/mcb_pkg.sv
// Types and constants shared by the arena allocator modules.
package mcb_pkg;

   // commands
   localparam logic [1:0] CMD_INIT   = 2'd0;
   localparam logic [1:0] CMD_ALLOC  = 2'd1;
   localparam logic [1:0] CMD_FREE   = 2'd2;
   localparam logic [1:0] CMD_RESIZE = 2'd3;

   // error codes
   localparam logic [1:0] ERR_NONE   = 2'd0;
   localparam logic [1:0] ERR_NOMEM  = 2'd1;
   localparam logic [1:0] ERR_BADBLK = 2'd2;

   // register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_ARENA_OWNER = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ARENA_TOP   = 1'b1;

   // reset values
   localparam logic [15:0] OWNER_RST = 16'h00F0;
   localparam logic [15:0] TOP_RST   = 16'h9FFF;
   localparam logic [15:0] FIRST_RST = 16'h00EF;

   // parameter defaults
   localparam int SEG_SPACE_DEF = 65536;
   localparam int MAX_WALK_DEF  = 32768;

   // one block header as stored, with its written mark
   typedef struct packed {
      logic        valid;
      logic        last;
      logic [15:0] owner;
      logic [15:0] size;
   } hdr_type;

   // header write request
   typedef struct packed {
      logic        en;
      logic [15:0] addr;
      hdr_type     hdr;
   } hdr_wr_type;

endpackage

// File: rtl/mcb_arena_allocator.sv
// Top level of the arena allocator: command sequencer, config registers, result register.
//
// Keeps a chain of block headers in one header memory and serves init, allocate,
// free and resize, one command at a time. After reset the header memory is
// cleared in a pass over all SEG_SPACE entries (65536 by default) during which
// req_stall stays high; csr writes are taken throughout. Init writes its header
// on acceptance; free and resize first read the header, and a shrinking resize
// or a splitting allocate writes a second header after the first. Allocate reads
// one header per cycle along the chain, visiting at most MAX_WALK headers. The
// next word is taken once the result is in the output register.
module mcb_arena_allocator #(
   parameter int SEG_SPACE = mcb_pkg::SEG_SPACE_DEF,
   parameter int MAX_WALK  = mcb_pkg::MAX_WALK_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_command,
   input  logic [15:0]                   req_block_seg,
   input  logic [15:0]                   req_paragraphs,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_ok,
   output logic [15:0]                   rsp_segment,
   output logic [1:0]                    rsp_error_code,
   // config port
   input  logic                          csr_we,
   input  logic [mcb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]                   csr_wdata
);
   import mcb_pkg::*;

   localparam int AW = $clog2(SEG_SPACE);
   localparam int NW = $clog2(MAX_WALK + 1);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_CHECK  = 3'd2;
   localparam logic [2:0] ST_WRITE2 = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [1:0]    cmd_ff, cmd_in;
   logic [15:0]   seg_ff, seg_in;
   logic [15:0]   req_ff, req_in;
   logic [15:0]   p_ff, p_in;
   logic          range_ff, range_in;
   logic [NW-1:0] n_ff, n_in;
   logic [15:0]   first_ff, first_in;
   hdr_type       w2_ff, w2_in;
   logic          res_ok_ff, res_ok_in;
   logic [15:0]   res_seg_ff, res_seg_in;
   logic [1:0]    res_err_ff, res_err_in;
   logic [15:0]   owner_ff, top_ff;
   logic          rsp_valid_ff;
   logic          rsp_ok_ff;
   logic [15:0]   rsp_seg_ff;
   logic [1:0]    rsp_err_ff;

   hdr_wr_type    wr;
   hdr_type       rd_q;
   logic          clear_busy;
   logic          accept;
   logic          rsp_free;
   logic          hv;
   logic          fit;
   logic          split_a;
   logic          walk_go;
   logic [15:0]   owner_m1;
   logic [15:0]   nx_a;
   logic [15:0]   nx_r;
   logic [15:0]   seg_a;
   logic [15:0]   next_p;

   // paragraph lies inside the header space
   function automatic logic in_range(input logic [15:0] p);
      in_range = {1'b0, p} < 17'(SEG_SPACE);
   endfunction

   mcb_hdr_ram #(
      .DEPTH (SEG_SPACE)
   ) u_hdr_ram (
      .clock      (clock),
      .reset      (reset),
      .wr         (wr),
      .rd_addr    (p_in[AW-1:0]),
      .rd_data    (rd_q),
      .clear_busy (clear_busy)
   );

   assign accept   = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // header checks on the word read last cycle
   assign hv       = rd_q.valid && range_ff;
   assign fit      = hv && (rd_q.owner == 16'd0) && (rd_q.size >= req_ff);
   assign split_a  = {1'b0, rd_q.size} > ({1'b0, req_ff} + 17'd1);
   assign owner_m1 = owner_ff - 16'd1;
   assign nx_a     = p_ff + 16'd1 + req_ff;
   assign nx_r     = seg_ff + req_ff;
   assign seg_a    = p_ff + 16'd1;
   assign next_p   = p_ff + 16'd1 + rd_q.size;
   assign walk_go  = (cmd_ff == CMD_ALLOC) && hv && !fit && !rd_q.last
                     && (n_ff != NW'(MAX_WALK - 1));

   // command sequencer
   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      seg_in     = seg_ff;
      req_in     = req_ff;
      p_in       = p_ff;
      n_in       = n_ff;
      first_in   = first_ff;
      w2_in      = w2_ff;
      res_ok_in  = res_ok_ff;
      res_seg_in = res_seg_ff;
      res_err_in = res_err_ff;
      wr         = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            if (!clear_busy) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cmd_in     = req_command;
               seg_in     = req_block_seg;
               req_in     = req_paragraphs;
               n_in       = '0;
               res_ok_in  = 1'b1;
               res_seg_in = 16'd0;
               res_err_in = ERR_NONE;
               unique case (req_command)
                  CMD_INIT: begin
                     first_in      = owner_m1;
                     wr.en         = in_range(owner_m1);
                     wr.addr       = owner_m1;
                     wr.hdr.valid  = 1'b1;
                     wr.hdr.last   = 1'b1;
                     wr.hdr.owner  = owner_ff;
                     wr.hdr.size   = top_ff - owner_ff;
                     state_in      = ST_DONE;
                  end
                  CMD_ALLOC: begin
                     p_in     = first_ff;
                     state_in = ST_CHECK;
                  end
                  default: begin
                     p_in     = req_block_seg - 16'd1;
                     state_in = ST_CHECK;
                  end
               endcase
            end
         end
         ST_CHECK: begin
            state_in = ST_DONE;
            case (cmd_ff)
               CMD_ALLOC: begin
                  if (fit) begin
                     if (seg_a == 16'd0) begin
                        res_ok_in  = 1'b0;
                        res_err_in = ERR_NOMEM;
                     end else begin
                        res_seg_in = seg_a;
                     end
                     if (split_a) begin
                        // free remainder first, owned header next cycle
                        wr.en        = in_range(nx_a);
                        wr.addr      = nx_a;
                        wr.hdr.valid = 1'b1;
                        wr.hdr.last  = rd_q.last;
                        wr.hdr.owner = 16'd0;
                        wr.hdr.size  = rd_q.size - req_ff - 16'd1;
                        w2_in.valid  = 1'b1;
                        w2_in.last   = 1'b0;
                        w2_in.owner  = owner_ff;
                        w2_in.size   = req_ff;
                        state_in     = ST_WRITE2;
                     end else begin
                        wr.en        = 1'b1;
                        wr.addr      = p_ff;
                        wr.hdr.valid = 1'b1;
                        wr.hdr.last  = rd_q.last;
                        wr.hdr.owner = owner_ff;
                        wr.hdr.size  = rd_q.size;
                     end
                  end else if (walk_go) begin
                     p_in     = next_p;
                     n_in     = n_ff + 1'b1;
                     state_in = ST_CHECK;
                  end else begin
                     // unwritten or out-of-range header, last block or walk limit
                     res_ok_in  = 1'b0;
                     res_err_in = ERR_NOMEM;
                  end
               end
               CMD_FREE: begin
                  wr.en        = hv;
                  wr.addr      = p_ff;
                  wr.hdr       = rd_q;
                  wr.hdr.owner = 16'd0;
               end
               CMD_RESIZE: begin
                  if (!hv) begin
                     res_ok_in  = 1'b0;
                     res_err_in = ERR_BADBLK;
                  end else if (req_ff < rd_q.size) begin
                     wr.en        = in_range(nx_r);
                     wr.addr      = nx_r;
                     wr.hdr.valid = 1'b1;
                     wr.hdr.last  = rd_q.last;
                     wr.hdr.owner = 16'd0;
                     wr.hdr.size  = rd_q.size - req_ff - 16'd1;
                     w2_in.valid  = 1'b1;
                     w2_in.last   = 1'b0;
                     w2_in.owner  = rd_q.owner;
                     w2_in.size   = req_ff;
                     state_in     = ST_WRITE2;
                  end else begin
                     wr.en        = 1'b1;
                     wr.addr      = p_ff;
                     wr.hdr       = rd_q;
                     wr.hdr.size  = req_ff;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_WRITE2: begin
            wr.en    = range_ff;
            wr.addr  = p_ff;
            wr.hdr   = w2_ff;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign range_in = in_range(p_in);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         first_ff <= FIRST_RST;
      end else begin
         state_ff <= state_in;
         first_ff <= first_in;
      end
   end

   // operation context and pending result
   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      seg_ff     <= seg_in;
      req_ff     <= req_in;
      p_ff       <= p_in;
      range_ff   <= range_in;
      n_ff       <= n_in;
      w2_ff      <= w2_in;
      res_ok_ff  <= res_ok_in;
      res_seg_ff <= res_seg_in;
      res_err_ff <= res_err_in;
   end

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         owner_ff <= OWNER_RST;
         top_ff   <= TOP_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ARENA_OWNER: owner_ff <= csr_wdata;
            CSR_ARENA_TOP:   top_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_DONE && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && rsp_free) begin
         rsp_ok_ff  <= res_ok_ff;
         rsp_seg_ff <= res_seg_ff;
         rsp_err_ff <= res_err_ff;
      end
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ok         = rsp_ok_ff;
   assign rsp_segment    = rsp_seg_ff;
   assign rsp_error_code = rsp_err_ff;

`include "mcb_arena_allocator_macros.svh"

   `MCB_ASSERT_NEXT(a_accept_moves, accept, (state_ff == ST_CHECK || state_ff == ST_DONE), "accepted word did not start a command")
   `MCB_ASSERT_NEXT(a_walk_count, (state_ff == ST_CHECK && walk_go), (n_ff == NW'($past(n_ff) + 1'b1)), "walk count did not advance")
   `MCB_ASSERT_NEXT(a_done_loads, (state_ff == ST_DONE && rsp_free), (rsp_valid_ff && state_ff == ST_IDLE), "result not loaded on completion")
   `MCB_ASSERT_IMPLY(a_ok_err, rsp_valid_ff, (rsp_ok_ff == (rsp_err_ff == ERR_NONE)), "ok flag disagrees with error code")

endmodule

// File: rtl/mcb_hdr_ram.sv
// Header memory: one write port, one registered read port, clearing sweep after reset.
module mcb_hdr_ram #(
   parameter int DEPTH = mcb_pkg::SEG_SPACE_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  mcb_pkg::hdr_wr_type      wr,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output mcb_pkg::hdr_type         rd_data,
   output logic                     clear_busy
);
   import mcb_pkg::*;

   localparam int AW = $clog2(DEPTH);

   hdr_type        mem [DEPTH];
   hdr_type        rd_q_ff;
   logic [AW-1:0]  clr_ff;
   logic [AW-1:0]  clr_in;
   logic           busy_ff;
   logic           busy_in;

   // clearing sweep: one entry per cycle from address 0
   always_comb begin
      clr_in  = clr_ff;
      busy_in = busy_ff;
      if (busy_ff) begin
         clr_in = clr_ff + 1'b1;
         if (clr_ff == AW'(DEPTH - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff  <= '0;
         busy_ff <= 1'b1;
      end else begin
         clr_ff  <= clr_in;
         busy_ff <= busy_in;
      end
   end

   // storage; the sweep has priority over writes
   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[clr_ff] <= '0;
      end else if (wr.en) begin
         mem[wr.addr[AW-1:0]] <= wr.hdr;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      rd_q_ff <= mem[rd_addr];
   end

   assign rd_data    = rd_q_ff;
   assign clear_busy = busy_ff;

endmodule

// File: test/tb_top.sv
// Self-checking testbench for the arena allocator: predicts every response word and compares it.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import mcb_pkg::*;

   // longest quiet stretch: clearing pass plus a full walk, several times over
   localparam int WATCHDOG_LIMIT = 400000;
   localparam int RANDOM_PHASE_WORDS = 117;

   typedef struct packed {
      logic        ok;
      logic [15:0] segment;
      logic [1:0]  error_code;
   } reply_type;

   // Arena predictor and store of expected response words
   class arena_tracker;
      bit                   hdr_written [SEG_SPACE_DEF];
      bit                   hdr_last    [SEG_SPACE_DEF];
      bit [15:0]            hdr_owner   [SEG_SPACE_DEF];
      bit [15:0]            hdr_size    [SEG_SPACE_DEF];
      bit [15:0]            first_hdr;
      bit [15:0]            owner_reg;
      bit [15:0]            top_reg;
      reply_type            expected_replies[$];
      int                   mismatches;

      function new();
         first_hdr = FIRST_RST;
         owner_reg = OWNER_RST;
         top_reg = TOP_RST;
         mismatches = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [15:0] val);
         if (idx == CSR_ARENA_OWNER) owner_reg = val;
         else if (idx == CSR_ARENA_TOP) top_reg = val;
      endfunction

      function void put_hdr(bit [15:0] p, bit last, bit [15:0] owner, bit [15:0] size);
         hdr_written[p] = 1'b1;
         hdr_last[p] = last;
         hdr_owner[p] = owner;
         hdr_size[p] = size;
      endfunction

      // first-fit walk; returns the data segment, 0 when nothing fits
      function bit [15:0] place_block(bit [15:0] req);
         bit [15:0] p;
         p = first_hdr;
         for (int n = 0; n < MAX_WALK_DEF; n++) begin
            if (!hdr_written[p]) return 16'd0;
            if (hdr_owner[p] == 16'd0 && hdr_size[p] >= req) begin
               if ({16'd0, hdr_size[p]} > {16'd0, req} + 32'd1) begin
                  put_hdr(p + 16'd1 + req, hdr_last[p], 16'd0, hdr_size[p] - req - 16'd1);
                  put_hdr(p, 1'b0, owner_reg, req);
               end else begin
                  put_hdr(p, hdr_last[p], owner_reg, hdr_size[p]);
               end
               return p + 16'd1;
            end
            if (hdr_last[p]) return 16'd0;
            p = p + 16'd1 + hdr_size[p];
         end
         return 16'd0;
      endfunction

      // size of some free block near the head of the chain, for exact-fit requests
      function bit [15:0] free_span();
         bit [15:0] p;
         bit [15:0] spans[$];
         p = first_hdr;
         for (int n = 0; n < 64; n++) begin
            if (!hdr_written[p]) break;
            if (hdr_owner[p] == 16'd0) spans.push_back(hdr_size[p]);
            if (hdr_last[p]) break;
            p = p + 16'd1 + hdr_size[p];
         end
         if (spans.size() == 0) return 16'($urandom_range(0, 64));
         return spans[$urandom_range(0, spans.size() - 1)];
      endfunction

      // apply one accepted request word and queue the response it must give
      function reply_type note_command(logic [1:0] cmd, logic [15:0] seg, logic [15:0] par);
         reply_type rw;
         bit [15:0] hp;
         bit        was_last;
         bit [15:0] was_owner;
         bit [15:0] was_size;
         rw.ok = 1'b1;
         rw.segment = 16'd0;
         rw.error_code = ERR_NONE;
         hp = seg - 16'd1;
         case (cmd)
            CMD_INIT: begin
               first_hdr = owner_reg - 16'd1;
               put_hdr(first_hdr, 1'b1, owner_reg, top_reg - owner_reg);
            end
            CMD_ALLOC: begin
               rw.segment = place_block(par);
               if (rw.segment == 16'd0) begin
                  rw.ok = 1'b0;
                  rw.error_code = ERR_NOMEM;
               end
            end
            CMD_FREE: begin
               // no check at all: just drop the owner if a header is there
               if (hdr_written[hp]) hdr_owner[hp] = 16'd0;
            end
            default: begin
               if (!hdr_written[hp]) begin
                  rw.ok = 1'b0;
                  rw.error_code = ERR_BADBLK;
               end else begin
                  was_last = hdr_last[hp];
                  was_owner = hdr_owner[hp];
                  was_size = hdr_size[hp];
                  // shrink splits off a free tail; grow just takes the new size
                  if (par < was_size) begin
                     put_hdr(seg + par, was_last, 16'd0, was_size - par - 16'd1);
                     put_hdr(hp, 1'b0, was_owner, par);
                  end else begin
                     put_hdr(hp, was_last, was_owner, par);
                  end
               end
            end
         endcase
         expected_replies.push_back(rw);
         return rw;
      endfunction

      task report_mismatch(string msg);
         $display("%0t mismatch: %s", $time, msg);
         mismatches++;
      endtask

      task check_reply(reply_type got);
         reply_type want;
         if (expected_replies.size() == 0) begin
            report_mismatch($sformatf("unexpected response word ok=%0b seg=%h err=%0d",
                                      got.ok, got.segment, got.error_code));
            return;
         end
         want = expected_replies.pop_front();
         if (got.ok !== want.ok)
            report_mismatch($sformatf("ok %0b, expected %0b", got.ok, want.ok));
         if (got.segment !== want.segment)
            report_mismatch($sformatf("segment %h, expected %h", got.segment, want.segment));
         if (got.error_code !== want.error_code)
            report_mismatch($sformatf("error_code %0d, expected %0d",
                                      got.error_code, want.error_code));
      endtask
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [1:0]           req_command;
   logic [15:0]          req_block_seg;
   logic [15:0]          req_paragraphs;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic                 rsp_ok;
   logic [15:0]          rsp_segment;
   logic [1:0]           rsp_error_code;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [15:0]          csr_wdata;

   arena_tracker tracker = new();
   logic [15:0]  live_segs[$];
   bit           calm = 1'b0;
   int           rsp_hold = 0;
   int           idle_cycles = 0;

   mcb_arena_allocator DUT (.*);

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // response side: random stall after each word taken
   always @(posedge clock) begin
      if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         tracker.check_reply({rsp_ok, rsp_segment, rsp_error_code});
         rsp_hold = calm ? 0 : $urandom_range(0, 7);
      end
      rsp_stall <= (rsp_hold != 0);
      if (rsp_hold != 0) rsp_hold--;
   end

   // watchdog: cycles with no word moving on any port
   always @(posedge clock) begin
      if (reset || csr_we || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL mcb_arena_allocator");
         $finish;
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [15:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      tracker.set_reg(idx, val);
   endtask

   // valid stays up between back-to-back words; it only drops for a gap
   task automatic send_word(logic [1:0] cmd, logic [15:0] seg, logic [15:0] par);
      int        gap;
      reply_type want;
      gap = calm ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_block_seg <= seg;
      req_paragraphs <= par;
      do @(posedge clock); while (req_stall !== 1'b0);
      want = tracker.note_command(cmd, seg, par);
      if (cmd == CMD_INIT) live_segs.delete();
      else if (cmd == CMD_ALLOC && want.ok) live_segs.push_back(want.segment);
   endtask

   // drain, then reprogram the arena registers
   task automatic start_phase(logic [15:0] owner, logic [15:0] top, bit quiet);
      req_valid <= 1'b0;
      while (tracker.expected_replies.size() != 0) @(posedge clock);
      @(posedge clock);
      calm = quiet;
      write_reg(CSR_ARENA_OWNER, owner);
      write_reg(CSR_ARENA_TOP, top);
      csr_we <= 1'b0;
   endtask

   // mostly init/free-arena/alloc/free/resize on live blocks, some noise
   task automatic run_random_phase(logic [15:0] owner, logic [15:0] top);
      int          r;
      int          pick;
      logic [15:0] seg;
      logic [15:0] par;
      start_phase(owner, top, 1'b0);
      send_word(CMD_INIT, 16'($urandom), 16'($urandom));
      send_word(CMD_FREE, tracker.owner_reg, 16'($urandom));
      for (int i = 0; i < RANDOM_PHASE_WORDS; i++) begin
         if (i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 99);
         seg = 16'($urandom);
         par = 16'($urandom_range(0, 64));
         if (r < 4 || live_segs.size() > 48) begin
            send_word(CMD_INIT, seg, par);
            if ($urandom_range(0, 9) != 0) send_word(CMD_FREE, tracker.owner_reg, par);
         end else if (r < 50) begin
            case ($urandom_range(0, 5))
               0, 1: par = tracker.free_span() - 16'($urandom_range(0, 1));
               2: par = 16'($urandom_range(0, 16'h0FFF));
               3: par = 16'($urandom);
               default: ;
            endcase
            send_word(CMD_ALLOC, seg, par);
         end else if (r < 70) begin
            if (live_segs.size() != 0 && $urandom_range(0, 7) != 0) begin
               pick = $urandom_range(0, live_segs.size() - 1);
               seg = live_segs[pick];
               // now and then keep it around for a double free
               if ($urandom_range(0, 9) != 0) live_segs.delete(pick);
            end
            send_word(CMD_FREE, seg, par);
         end else if (r < 92) begin
            if (live_segs.size() != 0 && $urandom_range(0, 4) != 0) begin
               seg = live_segs[$urandom_range(0, live_segs.size() - 1)];
               par = 16'($urandom_range(0, 80));
            end else begin
               par = 16'($urandom);
            end
            send_word(CMD_RESIZE, seg, par);
         end else begin
            send_word(2'($urandom_range(0, 3)), seg, 16'($urandom));
         end
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_command <= CMD_INIT;
      req_block_seg <= 16'd0;
      req_paragraphs <= 16'd0;
      rsp_stall <= 1'b0;
      csr_we <= 1'b0;
      csr_index <= CSR_ARENA_OWNER;
      csr_wdata <= 16'd0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // small arena of 16 paragraphs at 0x100; registers written during the clearing pass
      start_phase(16'h0100, 16'h0110, 1'b0);
      send_word(CMD_ALLOC, 16'h0000, 16'h0001);     // chain head never written
      send_word(CMD_RESIZE, 16'h1234, 16'h0005);    // bad block
      send_word(CMD_FREE, 16'h1234, 16'h0000);      // free of nothing
      send_word(CMD_INIT, 16'h0000, 16'h0000);
      send_word(CMD_FREE, 16'h0100, 16'h0000);      // release the program block
      send_word(CMD_ALLOC, 16'h0000, 16'hFFFF);     // too big
      send_word(CMD_RESIZE, 16'hFFFF, 16'hFFFF);
      send_word(CMD_FREE, 16'h0000, 16'h0000);
      send_word(CMD_ALLOC, 16'h0000, 16'h0010);     // exact fit
      send_word(CMD_FREE, 16'h0100, 16'h0000);
      send_word(CMD_ALLOC, 16'h0000, 16'h000F);     // one over: whole block taken
      send_word(CMD_FREE, 16'h0100, 16'h0000);
      send_word(CMD_ALLOC, 16'h0000, 16'h0000);     // zero-size split
      send_word(CMD_ALLOC, 16'h0000, 16'h000E);
      send_word(CMD_RESIZE, 16'h0101, 16'h0005);    // shrink
      send_word(CMD_RESIZE, 16'h0101, 16'h0008);    // grow
      send_word(CMD_RESIZE, 16'h0101, 16'hFFFF);    // block now points at itself
      send_word(CMD_ALLOC, 16'h0000, 16'h0001);     // walk runs out

      // zero owner: allocated blocks stay free, header at 0xFFFF wraps the segment
      start_phase(16'h0000, 16'h0020, 1'b1);
      send_word(CMD_INIT, 16'hFFFF, 16'hFFFF);
      send_word(CMD_ALLOC, 16'h0000, 16'h0004);
      send_word(CMD_ALLOC, 16'h0000, 16'h0005);
      send_word(CMD_ALLOC, 16'h0000, 16'h0005);

      // top of the segment space
      start_phase(16'hFFFF, 16'hFFFF, 1'b0);
      send_word(CMD_INIT, 16'h0000, 16'h0000);
      send_word(CMD_FREE, 16'hFFFF, 16'h0000);
      send_word(CMD_ALLOC, 16'h0000, 16'h0000);
      send_word(CMD_ALLOC, 16'h0000, 16'h0000);

      run_random_phase(16'h00F0, 16'h9FFF);
      run_random_phase(16'h0001, 16'hFFFF);
      run_random_phase(16'hFFFF, 16'h0001);
      run_random_phase(16'h1000, 16'h1040);
      run_random_phase(16'($urandom_range(1, 16'hFFFF)), 16'($urandom_range(1, 16'hFFFF)));
      run_random_phase(16'h8000, 16'h7FFF);

      req_valid <= 1'b0;
      while (tracker.expected_replies.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (tracker.mismatches == 0)
         $display("PASS mcb_arena_allocator");
      else
         $display("FAIL mcb_arena_allocator");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl
rtl/mcb_pkg.sv
rtl/mcb_hdr_ram.sv
rtl/mcb_arena_allocator.sv
test/tb_top.sv
